>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HBD_CHK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBD_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Types and constants of the block decoder with a postorder tree header.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_BLOCK     = 3'd1;
    localparam logic [2:0] ST_STREAM    = 3'd2;
    localparam logic [2:0] ST_BAD_COUNT = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;
    localparam logic [2:0] ST_SHAPE     = 3'd5;
    localparam logic [2:0] ST_DUP       = 3'd6;
    localparam logic [2:0] ST_TRUNC     = 3'd7;

    localparam int          SYM_W   = 9;
    localparam logic [8:0]  END_SYM = 9'd256;
    localparam logic [7:0]  ESC_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        PH_HI, PH_LO, PH_TREE, PH_SYMS, PH_CODE, PH_DONE, PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_BIT, SQ_POP, SQ_NODE, SQ_SYM, SQ_ROOTW, SQ_FLUSH
    } t_seq;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] status;
    } t_res;

endpackage

>>> hw/rtl/hbd_out.sv
// ----------------------------------------------------------------------------
// hbd_out
// Result buffer: one pending result plus the output register. The pending
// stage lets the last result of a byte be marked once the byte is finished.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_out
    import hbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res       i_res,
    input  logic       i_flush,
    input  logic       i_out_stall,
    output logic       o_ready,
    output logic       o_pend,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic r_pv;
    t_res r_pres;
    logic r_ov;
    t_res r_ores;
    logic r_olast;
    logic out_free;
    logic move;

    assign out_free = !r_ov || !i_out_stall;
    assign move     = r_pv && out_free && (i_push || i_flush);
    assign o_ready  = !r_pv || out_free;
    assign o_pend   = r_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (move) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_push) begin
                r_pv <= 1'b1;
            end else if (move) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_ores  <= r_pres;
            r_olast <= i_flush;
        end
        if (i_push) begin
            r_pres <= i_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ores.data;
    assign o_status    = r_ores.status;
    assign o_last      = r_olast;

    `HBD_CHK(a_push_room, i_push && r_pv, out_free, "push would drop a pending result")
    `HBD_CHK(a_push_flush, i_push, !i_flush, "push and flush in one cycle")
    `HBD_CHK_NEXT(a_pend_kept, r_pv && !out_free, r_pv, "pending result lost under stall")

endmodule

>>> hw/rtl/huffman_block_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_block_decoder_top
// Decodes blocks of a byte stream: node count, postorder tree bits, leaf
// symbols, then code bits walked through the node store.
// ----------------------------------------------------------------------------
// Header and symbol bytes are handled in SQ_IDLE; an error or a live stream
// end adds SQ_FLUSH, the last symbol SQ_ROOTW. A tree byte passes SQ_BIT per
// 0 bit and SQ_BIT, SQ_POP per 1 bit; a code byte passes SQ_BIT, SQ_NODE per
// inner-node step and also SQ_SYM per leaf (one read port per store), ending
// early at end of block. Both close in SQ_FLUSH; output stalls add to both.
// Reset is synchronous; stores are not cleared, the seen map clears at once.
`include "assert_macros.svh"

module huffman_block_decoder_top
    import hbd_pkg::*;
#(
    parameter int MAX_LEAVES = 257,
    parameter int MAX_NODES  = 513
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int LAW = $clog2(MAX_LEAVES);
    localparam int LW  = $clog2(MAX_LEAVES + 1);
    localparam int EW  = 1 + 2 * NAW;

    // stores
    logic [EW-1:0]    node_mem [MAX_NODES];
    logic [NAW-1:0]   stack_mem [MAX_LEAVES];
    logic [SYM_W-1:0] sym_mem [MAX_LEAVES];
    logic [EW-1:0]    r_node_q;
    logic [NAW-1:0]   r_stack_q;
    logic [SYM_W-1:0] r_sym_q;

    logic             node_re, node_we;
    logic [NAW-1:0]   node_ra, node_wa;
    logic [EW-1:0]    node_wd;
    logic             stack_re, stack_we;
    logic [LAW-1:0]   stack_ra, stack_wa;
    logic [NAW-1:0]   stack_wd;
    logic             sym_re, sym_we;
    logic [LAW-1:0]   sym_ra, sym_wa;
    logic [SYM_W-1:0] sym_wd;

    // control and datapath registers
    t_seq             r_seq, n_seq;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_hi, n_hi;
    logic [NW-1:0]    r_node_total, n_node_total;
    logic [NW-1:0]    r_bit_idx, n_bit_idx;
    logic [LW-1:0]    r_leaf, n_leaf;
    logic [LW-1:0]    r_inner, n_inner;
    logic [LW-1:0]    r_sym_idx, n_sym_idx;
    logic             r_esc, n_esc;
    logic [LW-1:0]    r_sp, n_sp;
    logic [NAW-1:0]   r_tos, n_tos;
    logic [EW-1:0]    r_went, n_went;
    logic [EW-1:0]    r_root, n_root;
    logic [7:0]       r_byte, n_byte;
    logic [3:0]       r_k, n_k;
    logic [255:0]     r_seen, n_seen;

    // result buffer handshake
    logic             push, flush, res_ready, res_pend;
    t_res             res;

    // decisions
    logic             acc;
    logic             cur_bit;
    logic             tree_stop;
    logic             shape_bad;
    logic             leaf_full;
    logic             sp_low;
    logic [15:0]      full_cnt;
    logic             bad_cnt;
    logic [SYM_W-1:0] sym_val;
    logic             sym_ok;
    logic             dup;
    logic             sym_last;
    logic [NAW-1:0]   next_node;
    logic             end_live;

    assign o_in_stall = (r_seq != SQ_IDLE);
    assign acc        = i_in_valid && (r_seq == SQ_IDLE);
    assign cur_bit    = r_byte[3'(3'd7 - r_k[2:0])];
    assign tree_stop  = (r_bit_idx >= r_node_total) || (r_k == 4'd8);
    assign shape_bad  = ({1'b0, r_inner} + (LW+1)'(1)) != {1'b0, r_leaf};
    assign leaf_full  = (r_leaf >= LW'(MAX_LEAVES)) || (r_sp >= LW'(MAX_LEAVES));
    assign sp_low     = r_sp < LW'(2);
    assign full_cnt   = {r_hi, i_data_byte};
    assign bad_cnt    = (full_cnt < 16'd3) || (full_cnt > 16'(MAX_NODES));
    assign sym_val    = r_esc ? ((i_data_byte == 8'h00) ? END_SYM : {1'b0, ESC_BYTE})
                              : {1'b0, i_data_byte};
    assign sym_ok     = r_esc || (i_data_byte != ESC_BYTE);
    assign dup        = sym_ok && !sym_val[8] && r_seen[sym_val[7:0]];
    assign sym_last   = ({1'b0, r_sym_idx} + (LW+1)'(1)) >= {1'b0, r_leaf};
    assign next_node  = cur_bit ? r_went[NAW-1:0] : r_went[2*NAW-1:NAW];
    assign end_live   = (r_phase != PH_DONE) && (r_phase != PH_ERR);

    // next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: begin
                if (acc) begin
                    if (i_stream_end) begin
                        n_seq = end_live ? SQ_FLUSH : SQ_IDLE;
                    end else begin
                        case (r_phase)
                            PH_LO:   n_seq = bad_cnt ? SQ_FLUSH : SQ_IDLE;
                            PH_TREE: n_seq = SQ_BIT;
                            PH_CODE: n_seq = SQ_BIT;
                            PH_SYMS: begin
                                if (dup) begin
                                    n_seq = SQ_FLUSH;
                                end else if (sym_ok && sym_last) begin
                                    n_seq = SQ_ROOTW;
                                end
                            end
                            default: n_seq = SQ_IDLE;
                        endcase
                    end
                end
            end
            SQ_BIT: begin
                if (r_phase == PH_TREE) begin
                    if (tree_stop) begin
                        n_seq = SQ_FLUSH;
                    end else if (!cur_bit) begin
                        n_seq = leaf_full ? SQ_FLUSH : SQ_BIT;
                    end else begin
                        n_seq = sp_low ? SQ_FLUSH : SQ_POP;
                    end
                end else begin
                    n_seq = (r_k == 4'd8) ? SQ_FLUSH : SQ_NODE;
                end
            end
            SQ_POP:   n_seq = SQ_BIT;
            SQ_NODE:  n_seq = r_node_q[EW-1] ? SQ_BIT : SQ_SYM;
            SQ_SYM: begin
                if (res_ready) begin
                    n_seq = (r_sym_q == END_SYM) ? SQ_FLUSH : SQ_BIT;
                end
            end
            SQ_ROOTW: n_seq = SQ_IDLE;
            SQ_FLUSH: begin
                if (!res_pend || res_ready) begin
                    n_seq = SQ_IDLE;
                end
            end
            default:  n_seq = SQ_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_phase      = r_phase;
        n_hi         = r_hi;
        n_node_total = r_node_total;
        n_bit_idx    = r_bit_idx;
        n_leaf       = r_leaf;
        n_inner      = r_inner;
        n_sym_idx    = r_sym_idx;
        n_esc        = r_esc;
        n_sp         = r_sp;
        n_tos        = r_tos;
        n_went       = r_went;
        n_root       = r_root;
        n_byte       = r_byte;
        n_k          = r_k;
        n_seen       = r_seen;
        push         = 1'b0;
        flush        = 1'b0;
        res          = '{data: 8'h00, status: ST_DATA};
        node_re      = 1'b0;
        node_ra      = NAW'(r_node_total - NW'(1));
        node_we      = 1'b0;
        node_wa      = r_bit_idx[NAW-1:0];
        node_wd      = '0;
        stack_re     = 1'b0;
        stack_ra     = LAW'(r_sp - LW'(2));
        stack_we     = 1'b0;
        stack_wa     = r_sp[LAW-1:0];
        stack_wd     = r_bit_idx[NAW-1:0];
        sym_re       = 1'b0;
        sym_ra       = r_node_q[LAW-1:0];
        sym_we       = 1'b0;
        sym_wa       = r_sym_idx[LAW-1:0];
        sym_wd       = sym_val;
        unique case (r_seq)
            SQ_IDLE: begin
                node_re = 1'b1;
                if (acc) begin
                    n_byte = i_data_byte;
                    n_k    = 4'd0;
                    if (i_stream_end) begin
                        if (r_phase == PH_HI) begin
                            push       = 1'b1;
                            res.status = ST_STREAM;
                            n_phase    = PH_DONE;
                        end else if (end_live) begin
                            push       = 1'b1;
                            res.status = ST_TRUNC;
                            n_phase    = PH_ERR;
                        end
                    end else begin
                        case (r_phase)
                            PH_HI: begin
                                n_hi    = i_data_byte;
                                n_phase = PH_LO;
                            end
                            PH_LO: begin
                                if (bad_cnt) begin
                                    push       = 1'b1;
                                    res.status = ST_BAD_COUNT;
                                    n_phase    = PH_ERR;
                                end else begin
                                    n_node_total = full_cnt[NW-1:0];
                                    n_bit_idx    = '0;
                                    n_leaf       = '0;
                                    n_inner      = '0;
                                    n_sp         = '0;
                                    n_seen       = '0;
                                    n_phase      = PH_TREE;
                                end
                            end
                            PH_SYMS: begin
                                if (!sym_ok) begin
                                    n_esc = 1'b1;
                                end else begin
                                    n_esc = 1'b0;
                                    if (dup) begin
                                        push       = 1'b1;
                                        res.status = ST_DUP;
                                        n_phase    = PH_ERR;
                                    end else begin
                                        if (!sym_val[8]) begin
                                            n_seen[sym_val[7:0]] = 1'b1;
                                        end
                                        sym_we    = r_sym_idx < LW'(MAX_LEAVES);
                                        n_sym_idx = r_sym_idx + LW'(1);
                                        if (sym_last) begin
                                            n_phase = PH_CODE;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            SQ_BIT: begin
                if (r_phase == PH_TREE) begin
                    if (tree_stop) begin
                        if (r_bit_idx >= r_node_total) begin
                            if (shape_bad) begin
                                push       = 1'b1;
                                res.status = ST_SHAPE;
                                n_phase    = PH_ERR;
                            end else begin
                                n_phase   = PH_SYMS;
                                n_sym_idx = '0;
                                n_esc     = 1'b0;
                            end
                        end
                    end else if (!cur_bit) begin
                        if (leaf_full) begin
                            push       = 1'b1;
                            res.status = ST_SHAPE;
                            n_phase    = PH_ERR;
                        end else begin
                            // push a leaf
                            node_we   = 1'b1;
                            node_wd   = {1'b0, NAW'(0), NAW'(r_leaf)};
                            stack_we  = 1'b1;
                            n_tos     = r_bit_idx[NAW-1:0];
                            n_sp      = r_sp + LW'(1);
                            n_leaf    = r_leaf + LW'(1);
                            n_bit_idx = r_bit_idx + NW'(1);
                            n_k       = r_k + 4'd1;
                        end
                    end else begin
                        if (sp_low) begin
                            push       = 1'b1;
                            res.status = ST_UNDERFLOW;
                            n_phase    = PH_ERR;
                        end else begin
                            stack_re = 1'b1;
                        end
                    end
                end else if (r_k != 4'd8) begin
                    node_re = 1'b1;
                    node_ra = next_node;
                end
            end
            SQ_POP: begin
                // left child from the stack, right child is the cached top
                node_we   = 1'b1;
                node_wd   = {1'b1, r_stack_q, r_tos};
                stack_we  = 1'b1;
                stack_wa  = LAW'(r_sp - LW'(2));
                n_tos     = r_bit_idx[NAW-1:0];
                n_sp      = r_sp - LW'(1);
                n_inner   = r_inner + LW'(1);
                n_bit_idx = r_bit_idx + NW'(1);
                n_k       = r_k + 4'd1;
            end
            SQ_NODE: begin
                if (r_node_q[EW-1]) begin
                    n_went = r_node_q;
                    n_k    = r_k + 4'd1;
                end else begin
                    sym_re = 1'b1;
                end
            end
            SQ_SYM: begin
                if (res_ready) begin
                    push = 1'b1;
                    if (r_sym_q == END_SYM) begin
                        res.status = ST_BLOCK;
                        n_phase    = PH_HI;
                    end else begin
                        res.data = r_sym_q[7:0];
                        n_went   = r_root;
                        n_k      = r_k + 4'd1;
                    end
                end
            end
            SQ_ROOTW: begin
                n_went = r_node_q;
                n_root = r_node_q;
            end
            SQ_FLUSH: flush = res_pend && res_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SQ_IDLE;
            r_phase      <= PH_HI;
            r_node_total <= '0;
            r_bit_idx    <= '0;
            r_leaf       <= '0;
            r_inner      <= '0;
            r_sym_idx    <= '0;
            r_esc        <= 1'b0;
            r_sp         <= '0;
            r_k          <= '0;
            r_seen       <= '0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_node_total <= n_node_total;
            r_bit_idx    <= n_bit_idx;
            r_leaf       <= n_leaf;
            r_inner      <= n_inner;
            r_sym_idx    <= n_sym_idx;
            r_esc        <= n_esc;
            r_sp         <= n_sp;
            r_k          <= n_k;
            r_seen       <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi   <= n_hi;
        r_tos  <= n_tos;
        r_went <= n_went;
        r_root <= n_root;
        r_byte <= n_byte;
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        if (node_re) begin
            r_node_q <= node_mem[node_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (stack_re) begin
            r_stack_q <= stack_mem[stack_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            sym_mem[sym_wa] <= sym_wd;
        end
        if (sym_re) begin
            r_sym_q <= sym_mem[sym_ra];
        end
    end

    hbd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (res),
        .i_flush     (flush),
        .i_out_stall (i_out_stall),
        .o_ready     (res_ready),
        .o_pend      (res_pend),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    `HBD_CHK_NEXT(a_err_sticky, r_phase == PH_ERR, r_phase == PH_ERR, "left error phase")
    `HBD_CHK_NEXT(a_done_sticky, r_phase == PH_DONE, r_phase == PH_DONE, "left done phase")
    `HBD_CHK(a_sp_bound, 1'b1, r_sp <= LW'(MAX_LEAVES), "node stack overrun")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block decoder testbench
// Sends one compressed stream of randomly built blocks, with trees, symbols
// and code bits generated here, and ends it with a randomly chosen end or
// error case. A scoreboard predicts every decoded beat and checks the outputs.
// ----------------------------------------------------------------------------
module testbench
    import hbd_pkg::*;
();

    localparam int LEAF_CAP = 257;
    localparam int NODE_CAP = 513;
    localparam logic [20:0] INNER_BIT = 21'h100000;

    typedef struct {
        logic [7:0] value;
        logic [2:0] status;
        logic       last;
    } t_dec_res;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_stim;

    class decode_scoreboard;
        t_dec_res    exp_q[$];
        t_dec_res    step_q[$];
        int          fails;
        t_phase      phase;
        int          node_total, bit_idx, leaf_total, inner_total;
        int          sym_idx, walk, stack_top;
        bit          escape;
        logic [9:0]  node_stack[LEAF_CAP];
        logic [20:0] node_store[NODE_CAP];
        logic [8:0]  leaf_sym[LEAF_CAP];
        bit          seen[256];

        function new();
            fails = 0;
            phase = PH_HI;
            node_total = 0; bit_idx = 0; leaf_total = 0; inner_total = 0;
            sym_idx = 0; walk = 0; stack_top = 0; escape = 0;
            foreach (node_stack[i]) node_stack[i] = '0;
            foreach (node_store[i]) node_store[i] = '0;
            foreach (leaf_sym[i]) leaf_sym[i] = '0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void flag(string msg);
            fails++;
            if (fails <= 10) $display("MISMATCH: %s", msg);
        endfunction

        function void emit(logic [7:0] v, logic [2:0] st);
            t_dec_res r;
            if (step_q.size() < 8) begin
                r.value = v; r.status = st; r.last = 0;
                step_q.push_back(r);
            end
        endfunction

        function void abort(logic [2:0] st);
            emit(8'h00, st);
            phase = PH_ERR;
        endfunction

        function logic [20:0] node_at(int i);
            return (i < NODE_CAP) ? node_store[i] : 21'h0;
        endfunction

        function void tree_byte(logic [7:0] b);
            int l, r;
            for (int k = 0; k < 8 && bit_idx < node_total; k++) begin
                if (!b[7-k]) begin
                    if (leaf_total >= LEAF_CAP || stack_top >= LEAF_CAP) begin
                        abort(ST_SHAPE);
                        return;
                    end
                    if (bit_idx < NODE_CAP) node_store[bit_idx] = {11'd0, 10'(leaf_total)};
                    node_stack[stack_top] = 10'(bit_idx);
                    stack_top++;
                    leaf_total++;
                end else begin
                    if (stack_top < 2) begin
                        abort(ST_UNDERFLOW);
                        return;
                    end
                    stack_top--; r = node_stack[stack_top];
                    stack_top--; l = node_stack[stack_top];
                    if (bit_idx < NODE_CAP) node_store[bit_idx] = {1'b1, 10'(l), 10'(r)};
                    node_stack[stack_top] = 10'(bit_idx);
                    stack_top++;
                    inner_total++;
                end
                bit_idx++;
            end
            if (bit_idx >= node_total) begin
                if (inner_total + 1 != leaf_total) begin
                    abort(ST_SHAPE);
                    return;
                end
                phase = PH_SYMS;
                sym_idx = 0;
                escape = 0;
            end
        endfunction

        function void symbol_byte(logic [7:0] b);
            logic [8:0] sym;
            if (escape) begin
                escape = 0;
                sym = (b == 8'h00) ? END_SYM : 9'h0FF;
            end else if (b == ESC_BYTE) begin
                escape = 1;
                return;
            end else begin
                sym = {1'b0, b};
            end
            if (sym != END_SYM) begin
                if (seen[sym[7:0]]) begin
                    abort(ST_DUP);
                    return;
                end
                seen[sym[7:0]] = 1;
            end
            if (sym_idx < LEAF_CAP) leaf_sym[sym_idx] = sym;
            sym_idx++;
            if (sym_idx >= leaf_total) begin
                phase = PH_CODE;
                walk = node_total - 1;
            end
        endfunction

        function void code_byte(logic [7:0] b);
            logic [20:0] e, ne;
            int nxt;
            logic [8:0] sym;
            for (int k = 0; k < 8; k++) begin
                e = node_at(walk);
                nxt = b[7-k] ? e[9:0] : e[19:10];
                ne = node_at(nxt);
                if (ne & INNER_BIT) begin
                    walk = nxt;
                end else begin
                    sym = (ne[9:0] < LEAF_CAP) ? leaf_sym[ne[9:0]] : 9'h0;
                    if (sym == END_SYM) begin
                        emit(8'h00, ST_BLOCK);
                        phase = PH_HI;
                        return;
                    end
                    emit(sym[7:0], ST_DATA);
                    walk = node_total - 1;
                end
            end
        endfunction

        function void note_beat(logic [7:0] b, logic fin);
            int full;
            step_q.delete();
            if (fin) begin
                if (phase == PH_HI) begin
                    emit(8'h00, ST_STREAM);
                    phase = PH_DONE;
                end else if (phase != PH_DONE && phase != PH_ERR) begin
                    abort(ST_TRUNC);
                end
            end else begin
                case (phase)
                    PH_HI: begin
                        node_total = b;
                        phase = PH_LO;
                    end
                    PH_LO: begin
                        full = ((node_total & 255) << 8) | b;
                        if (full < 3 || full > NODE_CAP) begin
                            abort(ST_BAD_COUNT);
                        end else begin
                            node_total = full;
                            bit_idx = 0; leaf_total = 0; inner_total = 0; stack_top = 0;
                            foreach (seen[i]) seen[i] = 0;
                            phase = PH_TREE;
                        end
                    end
                    PH_TREE: tree_byte(b);
                    PH_SYMS: symbol_byte(b);
                    PH_CODE: code_byte(b);
                    default: ;
                endcase
            end
            if (step_q.size() > 0) step_q[step_q.size()-1].last = 1;
            foreach (step_q[i]) exp_q.push_back(step_q[i]);
        endfunction

        function void check_beat(logic [7:0] v, logic [2:0] st, logic lst);
            t_dec_res x;
            if (exp_q.size() == 0) begin
                flag($sformatf("unexpected beat byte=%h status=%0d last=%b", v, st, lst));
                return;
            end
            x = exp_q.pop_front();
            if (v !== x.value || st !== x.status || lst !== x.last)
                flag($sformatf("exp byte=%h status=%0d last=%b, got byte=%h status=%0d last=%b",
                               x.value, x.status, x.last, v, st, lst));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_stream_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic [2:0] o_status;
    logic       o_last;

    huffman_block_decoder_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_data_byte(i_data_byte), .i_stream_end(i_stream_end),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_byte(o_out_byte), .o_status(o_status), .o_last(o_last)
    );

    decode_scoreboard sb;
    t_stim stim_q[$];
    int    beats_sent;
    int    g_par[NODE_CAP];
    bit    g_side[NODE_CAP];
    int    leaf_node[LEAF_CAP];
    int    pool[256];

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30000000;
        $display("testbench failed");
        $finish;
    end

    function automatic bit calm();
        return beats_sent >= stim_q.size() - 60;
    endfunction

    function automatic void add(logic [7:0] d, logic f);
        t_stim s;
        s.data = d; s.fin = f;
        stim_q.push_back(s);
    endfunction

    // pack bits into bytes, first bit in the MSB; pad the tail of the last byte with random bits
    function automatic void add_bits(ref bit q[$]);
        logic [7:0] v;
        for (int i = 0; i < q.size(); i += 8) begin
            v = 8'($urandom);
            for (int k = 0; k < 8; k++)
                if (i + k < q.size()) v[7-k] = q[i+k];
            add(v, 0);
        end
    endfunction

    // build a random full tree of nleaf leaves and the header, symbol and code bytes that carry it
    function automatic void gen_block(int nleaf, int nsyms, bit with_end);
        int stk[$];
        bit tbits[$];
        bit cbits[$];
        bit path[$];
        int leaves, i, l, r, n, end_ord, o, node, cnt, j, t;
        leaves = 0; i = 0;
        while (!(leaves == nleaf && stk.size() == 1)) begin
            if (stk.size() >= 2 && (leaves == nleaf || $urandom_range(1, 0) == 1)) begin
                r = stk.pop_back(); l = stk.pop_back();
                g_par[r] = i; g_side[r] = 1;
                g_par[l] = i; g_side[l] = 0;
                tbits.push_back(1);
            end else begin
                leaf_node[leaves] = i;
                leaves++;
                tbits.push_back(0);
            end
            stk.push_back(i);
            i++;
        end
        n = i;
        add(8'(n >> 8), 0);
        add(8'(n), 0);
        add_bits(tbits);
        for (j = 0; j < 256; j++) pool[j] = j;
        for (j = 255; j > 0; j--) begin
            o = $urandom_range(j, 0);
            t = pool[j]; pool[j] = pool[o]; pool[o] = t;
        end
        end_ord = with_end ? int'($urandom_range(nleaf - 1, 0)) : -1;
        cnt = 0;
        for (o = 0; o < nleaf; o++) begin
            if (o == end_ord) begin
                add(ESC_BYTE, 0);
                add(8'h00, 0);
            end else begin
                if (pool[cnt] == 255) add(ESC_BYTE, 0);
                add(8'(pool[cnt]), 0);
                cnt++;
            end
        end
        for (j = 0; j < nsyms + int'(with_end); j++) begin
            if (j == nsyms) o = end_ord;
            else begin
                o = $urandom_range(nleaf - 1, 0);
                while (o == end_ord) o = $urandom_range(nleaf - 1, 0);
            end
            node = leaf_node[o];
            path.delete();
            while (node != n - 1) begin
                path.push_front(g_side[node]);
                node = g_par[node];
            end
            foreach (path[k]) cbits.push_back(path[k]);
        end
        add_bits(cbits);
    endfunction

    function automatic void gen_finish();
        int cut, s, k;
        case ($urandom_range(6, 0))
            0: add(8'($urandom), 1);
            1: begin
                k = ($urandom_range(1, 0) == 0) ? int'($urandom_range(2, 0))
                                                : int'($urandom_range(65535, NODE_CAP + 1));
                add(8'(k >> 8), 0);
                add(8'(k), 0);
            end
            2: begin
                add(8'h00, 0); add(8'd5, 0);
                add(($urandom_range(1, 0) == 0) ? (8'h80 | 8'($urandom))
                                                : (8'h40 | (8'($urandom) & 8'h3F)), 0);
            end
            3: begin
                if ($urandom_range(1, 0) == 0) begin
                    k = 2 * $urandom_range(5, 2);
                    add(8'h00, 0); add(8'(k), 0);
                    add(8'($urandom), 0); add(8'($urandom), 0);
                end else begin
                    // more leaves than the store holds
                    add(8'h02, 0); add(8'h01, 0);
                    repeat (40) add(8'h00, 0);
                end
            end
            4: begin
                // three leaves, the second symbol repeats the first
                k = $urandom_range(254, 0);
                add(8'h00, 0); add(8'd5, 0); add(8'h28, 0);
                add(8'(k), 0); add(8'(k), 0);
            end
            5: begin
                s = stim_q.size();
                gen_block($urandom_range(8, 2), $urandom_range(6, 0), 1);
                cut = $urandom_range(stim_q.size() - 1, s + 1);
                while (stim_q.size() > cut) void'(stim_q.pop_back());
                add(8'($urandom), 1);
            end
            default: begin
                // tree without end symbol: decode until the input runs out
                gen_block($urandom_range(8, 2), 0, 0);
                repeat ($urandom_range(4, 1)) add(8'($urandom), 0);
                add(8'($urandom), 1);
            end
        endcase
        repeat (4) add(8'($urandom), 1'($urandom));
    endfunction

    task automatic send_beat(t_stim s);
        if (!calm() && $urandom_range(4, 0) == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(10, 1)) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_data_byte = s.data;
        i_stream_end = s.fin;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(s.data, s.fin);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // receiver side: random stall bursts, one long hold-off
    initial begin
        bit held_off;
        held_off = 0;
        i_out_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_out_stall = 0;
            if (!held_off && beats_sent >= 120) begin
                held_off = 1;
                i_out_stall = 1;
                repeat (1500) @(negedge i_clk);
                i_out_stall = 0;
            end else if (!calm() && $urandom_range(3, 0) == 0) begin
                i_out_stall = 1;
                repeat ($urandom_range(10, 1)) @(negedge i_clk);
                i_out_stall = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_out_byte, o_status, o_last);
    end

    initial begin
        sb = new();
        beats_sent = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_data_byte = '0;
        i_stream_end = 0;

        gen_block(2, 3, 1);
        gen_block(3, 5, 1);
        gen_block(LEAF_CAP, 6, 1);
        while (stim_q.size() < 370)
            gen_block(($urandom_range(9, 0) == 0) ? $urandom_range(40, 2)
                                                  : $urandom_range(8, 2),
                      $urandom_range(12, 0), 1);
        gen_finish();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        foreach (stim_q[i]) begin
            if (i == 360) begin
                // drain completely before going on
                i_in_valid = 0;
                while (sb.exp_q.size() != 0) @(negedge i_clk);
            end
            send_beat(stim_q[i]);
        end
        i_in_valid = 0;

        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
